[hw/rtl/bsdq_pkg.sv]
// ----------------------------------------------------------------------------
// bsdq_pkg
// Shared types and constants of the bounded sorted dedup queue.
// ----------------------------------------------------------------------------
package bsdq_pkg;

    localparam int DEFAULT_CAPACITY = 128;
    localparam int SEQ_W    = 31;
    localparam int RAW_W    = 32;
    localparam int PAY_W    = 32;
    localparam int TAG_W    = 64;
    localparam int IDX_W    = 7;
    localparam int CNT_OUT_W = 8;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_READ   = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_INSERTED      = 3'd0,
        ST_DUPLICATE     = 3'd1,
        ST_WRONG_SESSION = 3'd2,
        ST_BAD_SEQUENCE  = 3'd3,
        ST_CLEARED       = 3'd4,
        ST_READ_OK       = 3'd5,
        ST_READ_RANGE    = 3'd6
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SESSION_ID     = 1'd0,
        CFG_SESSION_ACTIVE = 1'd1
    } t_cfg_index;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_UPD  = 1'b1
    } t_state;

    // update command broadcast to every cell
    typedef struct packed {
        logic             upd;
        logic             full;
        logic [SEQ_W-1:0] seq;
        logic [PAY_W-1:0] pay;
    } t_cell_ctl;

endpackage

[hw/rtl/bsdq_cell.sv]
// ----------------------------------------------------------------------------
// bsdq_cell
// One slot of the sorted chain: holds an entry, compares it against the
// probe word and shifts toward either neighbor on an insert.
// ----------------------------------------------------------------------------
module bsdq_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 8,
    parameter int IW    = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_capture,
    input  logic [CW-1:0]            i_count,
    input  logic [bsdq_pkg::SEQ_W-1:0] i_probe_seq,
    input  logic [IW-1:0]            i_probe_idx,
    input  bsdq_pkg::t_cell_ctl      i_ctl,
    input  logic                     i_left_lt,
    input  logic                     i_right_lt,
    input  logic [bsdq_pkg::SEQ_W-1:0] i_left_seq,
    input  logic [bsdq_pkg::SEQ_W-1:0] i_right_seq,
    input  logic [bsdq_pkg::PAY_W-1:0] i_left_pay,
    input  logic [bsdq_pkg::PAY_W-1:0] i_right_pay,
    output logic                     o_lt,
    output logic                     o_eq,
    output logic                     o_hit,
    output logic [bsdq_pkg::SEQ_W-1:0] o_seq,
    output logic [bsdq_pkg::PAY_W-1:0] o_pay,
    output logic [bsdq_pkg::SEQ_W-1:0] o_rd_seq,
    output logic [bsdq_pkg::PAY_W-1:0] o_rd_pay
);

    logic [bsdq_pkg::SEQ_W-1:0] r_seq, n_seq;
    logic [bsdq_pkg::PAY_W-1:0] r_pay, n_pay;
    logic r_lt, r_eq, r_hit;
    logic w_valid;

    assign w_valid = CW'(INDEX) < i_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt  <= 1'b0;
            r_eq  <= 1'b0;
            r_hit <= 1'b0;
        end else if (i_capture) begin
            r_lt  <= w_valid && (r_seq < i_probe_seq);
            r_eq  <= w_valid && (r_seq == i_probe_seq);
            r_hit <= w_valid && (IW'(INDEX) == i_probe_idx);
        end
    end

    always_comb begin
        n_seq = r_seq;
        n_pay = r_pay;
        if (i_ctl.upd) begin
            if (i_ctl.full) begin
                // full: lower part moves down, smallest drops off
                if (i_right_lt) begin
                    n_seq = i_right_seq;
                    n_pay = i_right_pay;
                end else if (r_lt) begin
                    n_seq = i_ctl.seq;
                    n_pay = i_ctl.pay;
                end
            end else if (!r_lt) begin
                if (i_left_lt) begin
                    n_seq = i_ctl.seq;
                    n_pay = i_ctl.pay;
                end else begin
                    n_seq = i_left_seq;
                    n_pay = i_left_pay;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq <= n_seq;
        r_pay <= n_pay;
    end

    assign o_lt     = r_lt;
    assign o_eq     = r_eq;
    assign o_hit    = r_hit;
    assign o_seq    = r_seq;
    assign o_pay    = r_pay;
    assign o_rd_seq = r_hit ? r_seq : '0;
    assign o_rd_pay = r_hit ? r_pay : '0;

endmodule

[hw/rtl/bounded_sorted_dedup_queue.sv]
// ----------------------------------------------------------------------------
// bounded_sorted_dedup_queue
// Sorted store of up to CAPACITY entries kept in a chain of compare/shift
// cells, with duplicate drop, session check, eviction, clear and read.
// ----------------------------------------------------------------------------
//  channel   | handshake                | payload
//  ----------+--------------------------+------------------------------------
//  command   | start / busy             | opcode, tag, sequence, payload, idx
//  result    | o_valid (one cycle)      | status, evicted, sequences, count
//  config    | i_cfg_we                 | i_cfg_index, i_cfg_wdata
//
//  the accept edge latches the word and has every cell compare itself against
//  it; in the update state the chain shifts and the result is registered, so
//  o_valid rises in the cycle after busy.
//  busy is high only in the update state; a new word is taken only once busy
//  is low again, not at the edge that delivers the result. reset empties the store at once.
//  opcode three is taken and produces no result; the receiver cannot stall.
// ----------------------------------------------------------------------------
module bounded_sorted_dedup_queue #(
    parameter int CAPACITY = bsdq_pkg::DEFAULT_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_opcode,
    input  logic [bsdq_pkg::TAG_W-1:0]    i_session_tag,
    input  logic signed [bsdq_pkg::RAW_W-1:0] i_sequence_req,
    input  logic [bsdq_pkg::PAY_W-1:0]    i_payload_tag,
    input  logic [bsdq_pkg::IDX_W-1:0]    i_read_index,
    input  logic                          i_cfg_we,
    input  logic [bsdq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bsdq_pkg::CFG_W-1:0]    i_cfg_wdata,
    output logic                          o_valid,
    output logic [2:0]                    o_status,
    output logic                          o_evicted,
    output logic [bsdq_pkg::SEQ_W-1:0]    o_evicted_sequence,
    output logic [bsdq_pkg::SEQ_W-1:0]    o_read_sequence,
    output logic [bsdq_pkg::PAY_W-1:0]    o_read_payload,
    output logic [bsdq_pkg::CNT_OUT_W-1:0] o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > bsdq_pkg::IDX_W) ? CW : bsdq_pkg::IDX_W;

    bsdq_pkg::t_state r_state, n_state;

    logic [bsdq_pkg::TAG_W-1:0] r_session_id;
    logic                       r_session_active;

    logic [1:0]                 r_op;
    logic                       r_ses_ok, r_seq_ok;
    logic [bsdq_pkg::SEQ_W-1:0] r_seq;
    logic [bsdq_pkg::PAY_W-1:0] r_pay;
    logic [CW-1:0]              r_count, n_count;

    logic                       n_valid;
    bsdq_pkg::t_status          n_status;
    logic                       n_evicted;
    logic [bsdq_pkg::SEQ_W-1:0] n_ev_seq, n_rd_seq;
    logic [bsdq_pkg::PAY_W-1:0] n_rd_pay;
    logic                       r_valid;
    bsdq_pkg::t_status          r_status;
    logic                       r_evicted;
    logic [bsdq_pkg::SEQ_W-1:0] r_ev_seq, r_rd_seq;
    logic [bsdq_pkg::PAY_W-1:0] r_rd_pay;

    logic                       w_accept, w_full, w_dup, w_any_hit;
    logic [bsdq_pkg::SEQ_W-1:0] w_or_seq;
    logic [bsdq_pkg::PAY_W-1:0] w_or_pay;
    bsdq_pkg::t_cell_ctl        w_ctl;

    logic [CAPACITY+1:0]        w_ltv;
    logic [CAPACITY-1:0]        w_eq, w_hit;
    logic [bsdq_pkg::SEQ_W-1:0] w_seq    [CAPACITY];
    logic [bsdq_pkg::PAY_W-1:0] w_pay    [CAPACITY];
    logic [bsdq_pkg::SEQ_W-1:0] w_rd_seq [CAPACITY];
    logic [bsdq_pkg::PAY_W-1:0] w_rd_pay [CAPACITY];

    assign busy     = (r_state == bsdq_pkg::S_UPD);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(CAPACITY));

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session_id     <= '0;
            r_session_active <= 1'b0;
        end else if (i_cfg_we) begin
            case (bsdq_pkg::t_cfg_index'(i_cfg_index))
                bsdq_pkg::CFG_SESSION_ID:     r_session_id     <= i_cfg_wdata;
                bsdq_pkg::CFG_SESSION_ACTIVE: r_session_active <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // command word latch
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_opcode;
            r_ses_ok <= r_session_active && (i_session_tag == r_session_id);
            r_seq_ok <= !i_sequence_req[bsdq_pkg::RAW_W-1] && (i_sequence_req != '0);
            r_seq    <= i_sequence_req[bsdq_pkg::SEQ_W-1:0];
            r_pay    <= i_payload_tag;
        end
    end

    // cell chain
    assign w_ltv[0]          = 1'b1;
    assign w_ltv[CAPACITY+1] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [bsdq_pkg::SEQ_W-1:0] w_l_seq, w_r_seq;
        logic [bsdq_pkg::PAY_W-1:0] w_l_pay, w_r_pay;

        if (g == 0) begin : g_first
            assign w_l_seq = w_ctl.seq;
            assign w_l_pay = w_ctl.pay;
        end else begin : g_mid_l
            assign w_l_seq = w_seq[g-1];
            assign w_l_pay = w_pay[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_r_seq = w_ctl.seq;
            assign w_r_pay = w_ctl.pay;
        end else begin : g_mid_r
            assign w_r_seq = w_seq[g+1];
            assign w_r_pay = w_pay[g+1];
        end

        bsdq_cell #(
            .INDEX (g),
            .CW    (CW),
            .IW    (IW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_capture   (w_accept),
            .i_count     (r_count),
            .i_probe_seq (i_sequence_req[bsdq_pkg::SEQ_W-1:0]),
            .i_probe_idx (IW'(i_read_index)),
            .i_ctl       (w_ctl),
            .i_left_lt   (w_ltv[g]),
            .i_right_lt  (w_ltv[g+2]),
            .i_left_seq  (w_l_seq),
            .i_right_seq (w_r_seq),
            .i_left_pay  (w_l_pay),
            .i_right_pay (w_r_pay),
            .o_lt        (w_ltv[g+1]),
            .o_eq        (w_eq[g]),
            .o_hit       (w_hit[g]),
            .o_seq       (w_seq[g]),
            .o_pay       (w_pay[g]),
            .o_rd_seq    (w_rd_seq[g]),
            .o_rd_pay    (w_rd_pay[g])
        );
    end

    assign w_dup     = |w_eq;
    assign w_any_hit = |w_hit;

    always_comb begin
        w_or_seq = '0;
        w_or_pay = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_or_seq = w_or_seq | w_rd_seq[i];
            w_or_pay = w_or_pay | w_rd_pay[i];
        end
    end

    // sequencer and result
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_valid   = 1'b0;
        n_status  = bsdq_pkg::ST_INSERTED;
        n_evicted = 1'b0;
        n_ev_seq  = '0;
        n_rd_seq  = '0;
        n_rd_pay  = '0;
        w_ctl     = '{upd: 1'b0, full: w_full, seq: r_seq, pay: r_pay};
        case (r_state)
            bsdq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = bsdq_pkg::S_UPD;
                end
            end
            bsdq_pkg::S_UPD: begin
                n_state = bsdq_pkg::S_IDLE;
                n_valid = 1'b1;
                case (bsdq_pkg::t_opcode'(r_op))
                    bsdq_pkg::OP_INSERT: begin
                        if (!r_ses_ok) begin
                            n_status = bsdq_pkg::ST_WRONG_SESSION;
                        end else if (!r_seq_ok) begin
                            n_status = bsdq_pkg::ST_BAD_SEQUENCE;
                        end else if (w_dup) begin
                            n_status = bsdq_pkg::ST_DUPLICATE;
                        end else if (w_full) begin
                            n_evicted = 1'b1;
                            n_ev_seq  = w_ltv[1] ? w_seq[0] : r_seq;
                            w_ctl.upd = w_ltv[1];
                        end else begin
                            w_ctl.upd = 1'b1;
                            n_count   = r_count + 1'b1;
                        end
                    end
                    bsdq_pkg::OP_CLEAR: begin
                        n_status = bsdq_pkg::ST_CLEARED;
                        n_count  = '0;
                    end
                    bsdq_pkg::OP_READ: begin
                        n_status = w_any_hit ? bsdq_pkg::ST_READ_OK
                                             : bsdq_pkg::ST_READ_RANGE;
                        n_rd_seq = w_or_seq;
                        n_rd_pay = w_or_pay;
                    end
                    default: begin
                        n_valid = 1'b0;
                    end
                endcase
            end
            default: n_state = bsdq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsdq_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_evicted <= n_evicted;
        r_ev_seq  <= n_ev_seq;
        r_rd_seq  <= n_rd_seq;
        r_rd_pay  <= n_rd_pay;
    end

    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_evicted          = r_evicted;
    assign o_evicted_sequence = r_ev_seq;
    assign o_read_sequence    = r_rd_seq;
    assign o_read_payload     = r_rd_pay;
    assign o_entry_count      = bsdq_pkg::CNT_OUT_W'(r_count);

    // checks
    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held more than one cycle");

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a command in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_evict_only_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_evicted |-> o_status == bsdq_pkg::ST_INSERTED)
        else $error("eviction on a non-insert result");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == bsdq_pkg::ST_INSERTED && !o_evicted
            |-> r_count == $past(r_count) + 1'b1)
        else $error("insert without count growth");

endmodule

[test/bounded_sorted_dedup_queue_test.sv]
// ----------------------------------------------------------------------------
// bounded_sorted_dedup_queue_test
// Self-checking bench for the sorted dedup queue. A short table of directed
// words covers the session checks, bad sequences, duplicates, reads and
// clears. Random phases follow, each under its own session settings. Some
// phases fill the store past capacity to force evictions, and others favor
// duplicates or malformed words. A shadow store predicts every random result
// word; directed words are checked against the table.
module bounded_sorted_dedup_queue_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bsdq_pkg::*;

    localparam int          STORE_DEPTH  = DEFAULT_CAPACITY;
    localparam int          RANDOM_WORDS = 1130;
    localparam int          CYCLE_LIMIT  = 150000;
    localparam logic [1:0]  OPC_UNUSED   = 2'd3;
    localparam logic [63:0] T0           = 64'd0;
    localparam logic [63:0] T1           = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        t_status              status;
        logic                 evicted;
        logic [SEQ_W-1:0]     ev_seq;
        logic [SEQ_W-1:0]     rd_seq;
        logic [PAY_W-1:0]     rd_pay;
        logic [CNT_OUT_W-1:0] count;
    } result_t;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [TAG_W-1:0] tag;
        logic [RAW_W-1:0] seq;
        logic [PAY_W-1:0] pay;
        logic [IDX_W-1:0] idx;
    } cmd_word_t;

    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_SET_ID,
        ROW_SET_ACTIVE
    } row_kind_e;

    typedef struct packed {
        row_kind_e kind;
        cmd_word_t word;
        logic      typed;
        result_t   want;
    } dir_row_t;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DUPS,
        MIX_NOISE
    } mix_e;

    localparam result_t NO_RESULT = '0;

    function automatic result_t outcome(input t_status st, input logic [SEQ_W-1:0] rs,
                                        input logic [PAY_W-1:0] rp,
                                        input logic [CNT_OUT_W-1:0] cnt);
        result_t r;
        r        = NO_RESULT;
        r.status = st;
        r.rd_seq = rs;
        r.rd_pay = rp;
        r.count  = cnt;
        return r;
    endfunction

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           i_opcode;
    logic [TAG_W-1:0]     i_session_tag;
    logic [RAW_W-1:0]     i_sequence_req;
    logic [PAY_W-1:0]     i_payload_tag;
    logic [IDX_W-1:0]     i_read_index;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 o_valid;
    logic [2:0]           o_status;
    logic                 o_evicted;
    logic [SEQ_W-1:0]     o_evicted_sequence;
    logic [SEQ_W-1:0]     o_read_sequence;
    logic [PAY_W-1:0]     o_read_payload;
    logic [CNT_OUT_W-1:0] o_entry_count;

    // shadow copy of the store and the session registers
    logic [SEQ_W-1:0] shadow_seq [STORE_DEPTH];
    logic [PAY_W-1:0] shadow_pay [STORE_DEPTH];
    int               shadow_count;
    logic [TAG_W-1:0] shadow_sess_id;
    logic             shadow_sess_on;

    result_t awaited_results [$];
    logic    word_typed;
    result_t word_want;
    int      fail_count;
    int      cycle_count;

    dir_row_t directed_rows [25] = '{
        '{ROW_WORD, '{OP_READ, T0, 32'd0, 32'd0, 7'd0}, 1'b1,
          outcome(ST_READ_RANGE, 31'd0, 32'd0, 8'd0)},
        '{ROW_WORD, '{OP_INSERT, T0, 32'd5, 32'd0, 7'd0}, 1'b1,
          outcome(ST_WRONG_SESSION, 31'd0, 32'd0, 8'd0)},
        '{ROW_WORD, '{OP_CLEAR, T0, 32'd0, 32'd0, 7'd0}, 1'b1,
          outcome(ST_CLEARED, 31'd0, 32'd0, 8'd0)},
        '{ROW_WORD, '{OPC_UNUSED, T1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F}, 1'b0,
          NO_RESULT},
        '{ROW_SET_ACTIVE, '{OP_INSERT, 64'd1, 32'd0, 32'd0, 7'd0}, 1'b0, NO_RESULT},
        '{ROW_WORD, '{OP_INSERT, T0, 32'd5, 32'd0, 7'd0}, 1'b1,
          outcome(ST_INSERTED, 31'd0, 32'd0, 8'd1)},
        '{ROW_SET_ID, '{OP_INSERT, T1, 32'd0, 32'd0, 7'd0}, 1'b0, NO_RESULT},
        '{ROW_WORD, '{OP_INSERT, T0, 32'd5, 32'd0, 7'd0}, 1'b1,
          outcome(ST_WRONG_SESSION, 31'd0, 32'd0, 8'd1)},
        '{ROW_WORD, '{OP_INSERT, T1, 32'd0, 32'd0, 7'd0}, 1'b1,
          outcome(ST_BAD_SEQUENCE, 31'd0, 32'd0, 8'd1)},
        '{ROW_WORD, '{OP_INSERT, T1, 32'h8000_0000, 32'd0, 7'd0}, 1'b1,
          outcome(ST_BAD_SEQUENCE, 31'd0, 32'd0, 8'd1)},
        // session is checked before the sequence
        '{ROW_WORD, '{OP_INSERT, T0, 32'd0, 32'd0, 7'd0}, 1'b1,
          outcome(ST_WRONG_SESSION, 31'd0, 32'd0, 8'd1)},
        '{ROW_WORD, '{OP_INSERT, T1, 32'hFFFF_FFFF, 32'd0, 7'd0}, 1'b1,
          outcome(ST_BAD_SEQUENCE, 31'd0, 32'd0, 8'd1)},
        '{ROW_WORD, '{OP_INSERT, T1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 7'd0}, 1'b1,
          outcome(ST_INSERTED, 31'd0, 32'd0, 8'd2)},
        '{ROW_WORD, '{OP_INSERT, T1, 32'd1, 32'd0, 7'd0}, 1'b1,
          outcome(ST_INSERTED, 31'd0, 32'd0, 8'd3)},
        '{ROW_WORD, '{OP_INSERT, T1, 32'd5, 32'd1234, 7'd0}, 1'b1,
          outcome(ST_DUPLICATE, 31'd0, 32'd0, 8'd3)},
        '{ROW_WORD, '{OP_READ, T0, 32'd0, 32'd0, 7'd0}, 1'b1,
          outcome(ST_READ_OK, 31'd1, 32'd0, 8'd3)},
        '{ROW_WORD, '{OP_READ, T0, 32'd0, 32'd0, 7'd1}, 1'b1,
          outcome(ST_READ_OK, 31'd5, 32'd0, 8'd3)},
        '{ROW_WORD, '{OP_READ, T0, 32'd0, 32'd0, 7'd2}, 1'b1,
          outcome(ST_READ_OK, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 8'd3)},
        '{ROW_WORD, '{OP_READ, T0, 32'd0, 32'd0, 7'd3}, 1'b1,
          outcome(ST_READ_RANGE, 31'd0, 32'd0, 8'd3)},
        '{ROW_WORD, '{OP_READ, T0, 32'd0, 32'd0, 7'd127}, 1'b1,
          outcome(ST_READ_RANGE, 31'd0, 32'd0, 8'd3)},
        '{ROW_WORD, '{OP_CLEAR, T1, 32'hFFFF_FFFF, 32'd0, 7'd0}, 1'b1,
          outcome(ST_CLEARED, 31'd0, 32'd0, 8'd0)},
        '{ROW_WORD, '{OP_READ, T0, 32'd0, 32'd0, 7'd0}, 1'b1,
          outcome(ST_READ_RANGE, 31'd0, 32'd0, 8'd0)},
        '{ROW_SET_ACTIVE, '{OP_INSERT, T0, 32'd0, 32'd0, 7'd0}, 1'b0, NO_RESULT},
        '{ROW_WORD, '{OP_INSERT, T1, 32'd9, 32'd0, 7'd0}, 1'b1,
          outcome(ST_WRONG_SESSION, 31'd0, 32'd0, 8'd0)},
        '{ROW_SET_ACTIVE, '{OP_INSERT, 64'd1, 32'd0, 32'd0, 7'd0}, 1'b0, NO_RESULT}
    };

    bounded_sorted_dedup_queue #(
        .CAPACITY(STORE_DEPTH)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_session_tag      (i_session_tag),
        .i_sequence_req     (i_sequence_req),
        .i_payload_tag      (i_payload_tag),
        .i_read_index       (i_read_index),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_evicted          (o_evicted),
        .o_evicted_sequence (o_evicted_sequence),
        .o_read_sequence    (o_read_sequence),
        .o_read_payload     (o_read_payload),
        .o_entry_count      (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // returns 0 when the word yields no result
    function automatic bit update_store(input cmd_word_t w, output result_t r);
        int pos;
        int i;
        bit stop;
        bit dup;
        r = NO_RESULT;
        case (w.opcode)
            OP_INSERT: begin
                if (!shadow_sess_on || w.tag != shadow_sess_id) begin
                    r.status = ST_WRONG_SESSION;
                end else if (w.seq == '0 || w.seq[RAW_W-1]) begin
                    r.status = ST_BAD_SEQUENCE;
                end else begin
                    pos  = 0;
                    stop = 1'b0;
                    dup  = 1'b0;
                    while (pos < shadow_count && !stop) begin
                        if (shadow_seq[pos] == w.seq[SEQ_W-1:0]) begin
                            dup  = 1'b1;
                            stop = 1'b1;
                        end else if (shadow_seq[pos] > w.seq[SEQ_W-1:0]) begin
                            stop = 1'b1;
                        end else begin
                            pos++;
                        end
                    end
                    if (dup) begin
                        r.status = ST_DUPLICATE;
                    end else if (shadow_count >= STORE_DEPTH) begin
                        r.status  = ST_INSERTED;
                        r.evicted = 1'b1;
                        if (pos == 0) begin
                            r.ev_seq = w.seq[SEQ_W-1:0];
                        end else begin
                            r.ev_seq = shadow_seq[0];
                            for (i = 1; i < pos; i++) begin
                                shadow_seq[i-1] = shadow_seq[i];
                                shadow_pay[i-1] = shadow_pay[i];
                            end
                            shadow_seq[pos-1] = w.seq[SEQ_W-1:0];
                            shadow_pay[pos-1] = w.pay;
                        end
                    end else begin
                        r.status = ST_INSERTED;
                        for (i = shadow_count; i > pos; i--) begin
                            shadow_seq[i] = shadow_seq[i-1];
                            shadow_pay[i] = shadow_pay[i-1];
                        end
                        shadow_seq[pos] = w.seq[SEQ_W-1:0];
                        shadow_pay[pos] = w.pay;
                        shadow_count++;
                    end
                end
            end
            OP_CLEAR: begin
                shadow_count = 0;
                r.status     = ST_CLEARED;
            end
            OP_READ: begin
                if (int'(w.idx) < shadow_count) begin
                    r.status = ST_READ_OK;
                    r.rd_seq = shadow_seq[w.idx];
                    r.rd_pay = shadow_pay[w.idx];
                end else begin
                    r.status = ST_READ_RANGE;
                end
            end
            default: begin
                return 1'b0;
            end
        endcase
        r.count = CNT_OUT_W'(shadow_count);
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        result_t   got;
        result_t   want;
        result_t   oldest;
        cmd_word_t w;
        if (!i_rst_n) begin
            shadow_count   = 0;
            shadow_sess_id = '0;
            shadow_sess_on = 1'b0;
            awaited_results.delete();
        end else begin
            if (o_valid) begin
                got.status  = t_status'(o_status);
                got.evicted = o_evicted;
                got.ev_seq  = o_evicted_sequence;
                got.rd_seq  = o_read_sequence;
                got.rd_pay  = o_read_payload;
                got.count   = o_entry_count;
                if (awaited_results.size() == 0) begin
                    $error("result word with none awaited, status %0d", o_status);
                    fail_count++;
                end else begin
                    oldest = awaited_results.pop_front();
                    check_field("status", oldest.status, got.status);
                    check_field("evicted", oldest.evicted, got.evicted);
                    check_field("evicted_sequence", oldest.ev_seq, got.ev_seq);
                    check_field("read_sequence", oldest.rd_seq, got.rd_seq);
                    check_field("read_payload", oldest.rd_pay, got.rd_pay);
                    check_field("entry_count", oldest.count, got.count);
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_SESSION_ID:     shadow_sess_id = i_cfg_wdata;
                    CFG_SESSION_ACTIVE: shadow_sess_on = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                w = '{i_opcode, i_session_tag, i_sequence_req, i_payload_tag, i_read_index};
                if (update_store(w, want)) begin
                    awaited_results.push_back(word_typed ? word_want : want);
                end
            end
        end
    end

    task automatic send_word(input cmd_word_t w, input logic typed, input result_t want);
        @(negedge i_clk);
        start          <= 1'b1;
        i_opcode       <= w.opcode;
        i_session_tag  <= w.tag;
        i_sequence_req <= w.seq;
        i_payload_tag  <= w.pay;
        i_read_index   <= w.idx;
        word_typed     <= typed;
        word_want      <= want;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic maybe_pause(input int pct);
        if ($urandom_range(0, 99) < pct) hold_off($urandom_range(1, 7));
    endtask

    // also covers a trailing unused-opcode word still in flight
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic cmd_word_t random_word(input mix_e mode);
        cmd_word_t w;
        int pick;
        pick  = $urandom_range(0, 99);
        w.tag = {$urandom, $urandom};
        w.seq = $urandom;
        w.pay = $urandom;
        w.idx = $urandom_range(0, 127);
        if ($urandom_range(0, 1) != 0 && shadow_count > 0) begin
            w.idx = $urandom_range(0, shadow_count - 1);
        end
        case (mode)
            MIX_FILL:  w.opcode = (pick < 88) ? OP_INSERT : (pick < 98) ? OP_READ : OPC_UNUSED;
            MIX_DUPS:  w.opcode = (pick < 60) ? OP_INSERT : (pick < 85) ? OP_READ :
                                  (pick < 92) ? OP_CLEAR : OPC_UNUSED;
            default:   w.opcode = (pick < 45) ? OP_INSERT : (pick < 75) ? OP_READ :
                                  (pick < 88) ? OP_CLEAR : OPC_UNUSED;
        endcase
        if (w.opcode == OP_INSERT) begin
            w.tag = shadow_sess_id;
            case ($urandom_range(0, 3))
                0:       w.seq = $urandom_range(1, 200);
                1, 2:    w.seq = $urandom_range(1, 5000);
                default: w.seq = $urandom_range(1, 32'h7FFF_FFFF);
            endcase
            if (mode == MIX_DUPS) w.seq = $urandom_range(1, 40);
            if (mode != MIX_FILL) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: w.tag = {$urandom, $urandom};
                    3, 4:    w.seq = ($urandom_range(0, 1) != 0) ? 32'd0
                                                                 : ($urandom | 32'h8000_0000);
                    default: ;
                endcase
            end
        end
        return w;
    endfunction

    initial begin : stimulus
        cmd_word_t   w;
        logic [63:0] data;
        mix_e        mode;
        int          sent;
        int          phase;
        int          batch;
        int          pct;
        int          k;
        bit          quiet;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_opcode       = OP_INSERT;
        i_session_tag  = '0;
        i_sequence_req = '0;
        i_payload_tag  = '0;
        i_read_index   = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_SESSION_ID;
        i_cfg_wdata    = '0;
        word_typed     = 1'b0;
        word_want      = NO_RESULT;
        fail_count     = 0;
        cycle_count    = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            case (directed_rows[n].kind)
                ROW_WORD: begin
                    send_word(directed_rows[n].word, directed_rows[n].typed,
                              directed_rows[n].want);
                    maybe_pause(30);
                end
                ROW_SET_ID: begin
                    drain_results();
                    write_reg(CFG_SESSION_ID, directed_rows[n].word.tag);
                end
                default: begin
                    drain_results();
                    write_reg(CFG_SESSION_ACTIVE, directed_rows[n].word.tag);
                end
            endcase
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            drain_results();
            mode = (phase == 0 || phase == 3) ? MIX_FILL : mix_e'($urandom_range(0, 2));
            case (phase == 0 ? 0 : phase == 1 ? 1 : $urandom_range(0, 3))
                0:       data = '0;
                1:       data = '1;
                default: data = {$urandom, $urandom};
            endcase
            write_reg(CFG_SESSION_ID, data);
            data    = {$urandom, $urandom};
            data[0] = (mode == MIX_FILL) || ($urandom_range(0, 4) != 0);
            write_reg(CFG_SESSION_ACTIVE, data);
            batch = (mode == MIX_FILL) ? $urandom_range(180, 260) : $urandom_range(50, 140);
            quiet = (sent >= RANDOM_WORDS - 150);
            // the closing stretch runs as one batch with no gaps
            if (quiet) begin
                batch = RANDOM_WORDS;
            end else if (batch > RANDOM_WORDS - 150 - sent) begin
                batch = RANDOM_WORDS - 150 - sent;
            end
            case ($urandom_range(0, 2))
                0:       pct = 0;
                1:       pct = 15;
                default: pct = 40;
            endcase
            if (quiet) pct = 0;
            for (k = 0; k < batch && sent < RANDOM_WORDS; k++) begin
                w = random_word(mode);
                if (w.opcode != OPC_UNUSED) sent++;
                send_word(w, 1'b0, NO_RESULT);
                if (!quiet && $urandom_range(0, 199) == 0) drain_results();
                else maybe_pause(pct);
            end
            phase++;
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
